// ----- hw/rtl/weighted_target_selector_assert.svh -----
// Assertion macros for the RTL of the target selector.
`ifndef WEIGHTED_TARGET_SELECTOR_ASSERT_SVH
`define WEIGHTED_TARGET_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/wts_pkg.sv -----
// ----------------------------------------------------------------------------
// wts_pkg
// Types, widths and codes shared by the weighted target selector.
// ----------------------------------------------------------------------------
package wts_pkg;

    localparam int MAX_BOXES    = 32;
    localparam int CNT_W        = $clog2(MAX_BOXES + 1);
    localparam int IDX_W        = $clog2(MAX_BOXES);
    localparam int COORD_W      = 12;
    localparam int CLS_W        = 4;
    localparam int WT_W         = 16;
    localparam int CHOSEN_IDX_W = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int SQ_W         = 25;   // dx*dx + dy*dy
    localparam int ROOT_W       = 13;
    localparam int MA_W         = 25;
    localparam int MB_W         = 17;
    localparam int PROD_W       = MA_W + MB_W;
    localparam int SCORE_W      = PROD_W + 1;

    localparam logic [CLS_W-1:0] CLS_BASE     = 4'd3;
    localparam logic [CLS_W-1:0] CLS_STANDARD = 4'd4;
    localparam logic [CLS_W-1:0] CLS_HERO     = 4'd5;
    localparam logic [CLS_W-1:0] CLS_SENTRY   = 4'd6;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [CLS_W-1:0]   cls;
    } t_box;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENEMY_COLOR     = 3'd0,
        CFG_WEIGHT_BASE     = 3'd1,
        CFG_WEIGHT_STANDARD = 3'd2,
        CFG_WEIGHT_HERO     = 3'd3,
        CFG_WEIGHT_SENTRY   = 3'd4,
        CFG_WEIGHT_SIZE     = 3'd5,
        CFG_WEIGHT_DIST     = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_RD,
        ST_PRE_GO,
        ST_PRE_WAIT,
        ST_OUT_RD,
        ST_OUT_LATCH,
        ST_IN_RD,
        ST_IN_CHK,
        ST_VEH_DONE,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DX,
        CS_DY,
        CS_AREA,
        CS_SIZE,
        CS_SAVE,
        CS_ROOT,
        CS_DIST
    } t_cs;

endpackage

// ----- hw/rtl/wts_isqrt.sv -----
// ----------------------------------------------------------------------------
// wts_isqrt
// Iterative floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wts_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wts_pkg::SQ_W-1:0]    i_value,
    output logic                        o_done,
    output logic [wts_pkg::ROOT_W-1:0]  o_root
);

    localparam int W = wts_pkg::SQ_W + 1;
    // Highest even power of two that fits the radicand.
    localparam int TOP = ((wts_pkg::SQ_W - 1) / 2) * 2;

    logic [W-1:0] r_v, r_res, r_bit;
    logic         r_busy, r_done;
    logic [W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= W'(i_value);
            r_res <= '0;
            r_bit <= W'(1) << TOP;
        end else if (r_busy && r_bit != '0) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[wts_pkg::ROOT_W-1:0];

endmodule

// ----- hw/rtl/wts_score.sv -----
// ----------------------------------------------------------------------------
// wts_score
// Child score: area times size weight plus distance times distance weight,
// worked out on one shared multiplier and the square root unit.
// ----------------------------------------------------------------------------
module wts_score (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  wts_pkg::t_box                     i_box,
    input  logic [wts_pkg::COORD_W-1:0]       i_last_x,
    input  logic [wts_pkg::COORD_W-1:0]       i_last_y,
    input  logic [wts_pkg::WT_W-1:0]          i_weight_size,
    input  logic signed [wts_pkg::WT_W-1:0]   i_weight_dist,
    output logic                              o_done,
    output logic signed [wts_pkg::SCORE_W-1:0] o_score
);

    wts_pkg::t_cs r_cs, n_cs;

    logic signed [wts_pkg::COORD_W:0]     r_dx, r_dy;
    logic [wts_pkg::COORD_W-1:0]          r_w, r_h;
    logic signed [wts_pkg::MA_W-1:0]      m_a;
    logic signed [wts_pkg::MB_W-1:0]      m_b;
    logic signed [wts_pkg::PROD_W-1:0]    m_p, r_prod, r_acc;
    logic [wts_pkg::SQ_W-1:0]             r_sq;
    logic [wts_pkg::ROOT_W-1:0]           r_root, root;
    logic                                 sq_start, sq_done, r_done;

    wts_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sq),
        .o_done  (sq_done),
        .o_root  (root)
    );

    always_comb begin
        n_cs = r_cs;
        unique case (r_cs)
            wts_pkg::CS_IDLE: if (i_start) n_cs = wts_pkg::CS_DX;
            wts_pkg::CS_DX:   n_cs = wts_pkg::CS_DY;
            wts_pkg::CS_DY:   n_cs = wts_pkg::CS_AREA;
            wts_pkg::CS_AREA: n_cs = wts_pkg::CS_SIZE;
            wts_pkg::CS_SIZE: n_cs = wts_pkg::CS_SAVE;
            wts_pkg::CS_SAVE: n_cs = wts_pkg::CS_ROOT;
            wts_pkg::CS_ROOT: if (sq_done) n_cs = wts_pkg::CS_DIST;
            wts_pkg::CS_DIST: n_cs = wts_pkg::CS_IDLE;
            default:          n_cs = wts_pkg::CS_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        m_a      = '0;
        m_b      = '0;
        sq_start = 1'b0;
        unique case (r_cs)
            wts_pkg::CS_DX: begin
                m_a = wts_pkg::MA_W'(r_dx);
                m_b = wts_pkg::MB_W'(r_dx);
            end
            wts_pkg::CS_DY: begin
                m_a = wts_pkg::MA_W'(r_dy);
                m_b = wts_pkg::MB_W'(r_dy);
            end
            wts_pkg::CS_AREA: begin
                m_a = $signed(wts_pkg::MA_W'(r_w));
                m_b = $signed(wts_pkg::MB_W'(r_h));
            end
            wts_pkg::CS_SIZE: begin
                m_a = $signed(wts_pkg::MA_W'(r_prod[2*wts_pkg::COORD_W-1:0]));
                m_b = $signed(wts_pkg::MB_W'(i_weight_size));
            end
            wts_pkg::CS_SAVE: sq_start = 1'b1;
            wts_pkg::CS_DIST: begin
                m_a = $signed(wts_pkg::MA_W'(r_root));
                m_b = wts_pkg::MB_W'(i_weight_dist);
            end
            default: begin
            end
        endcase
    end

    assign m_p = m_a * m_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= wts_pkg::CS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_cs   <= n_cs;
            r_done <= (r_cs == wts_pkg::CS_DIST);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        if (r_cs == wts_pkg::CS_IDLE && i_start) begin
            r_dx <= $signed({1'b0, i_box.x}) - $signed({1'b0, i_last_x});
            r_dy <= $signed({1'b0, i_box.y}) - $signed({1'b0, i_last_y});
            r_w  <= i_box.w;
            r_h  <= i_box.h;
        end
        if (r_cs == wts_pkg::CS_DY)   r_sq <= r_prod[wts_pkg::SQ_W-1:0];
        if (r_cs == wts_pkg::CS_AREA) r_sq <= r_sq + r_prod[wts_pkg::SQ_W-1:0];
        if (r_cs == wts_pkg::CS_SAVE) r_acc <= r_prod;
        if (r_cs == wts_pkg::CS_ROOT && sq_done) r_root <= root;
    end

    // The distance product lands in r_prod in the cycle after CS_DIST.
    assign o_done  = r_done;
    assign o_score = {r_acc[wts_pkg::PROD_W-1], r_acc} + {r_prod[wts_pkg::PROD_W-1], r_prod};

endmodule

// ----- hw/rtl/weighted_target_selector.sv -----
// A box that does not end the frame is stored while busy stays low.
// A final box starts the scan: every stored box is first scored as a
// child, then every stored box is read and each vehicle box is checked against all
// stored boxes, on one shared multiplier, square root unit and store read port.
// One result per frame, shown for one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties the frame and clears the last target.
// ----------------------------------------------------------------------------
// weighted_target_selector
// Stores a frame of boxes and picks the best vehicle holding enemy armour.
// ----------------------------------------------------------------------------
`include "weighted_target_selector_assert.svh"

module weighted_target_selector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [wts_pkg::COORD_W-1:0]          i_box_x,
    input  logic [wts_pkg::COORD_W-1:0]          i_box_y,
    input  logic [wts_pkg::COORD_W-1:0]          i_box_w,
    input  logic [wts_pkg::COORD_W-1:0]          i_box_h,
    input  logic [wts_pkg::CLS_W-1:0]            i_box_class,
    input  logic                                 i_last_box,
    input  logic                                 i_cfg_we,
    input  logic [wts_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wts_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [wts_pkg::CHOSEN_IDX_W-1:0]     o_chosen_index,
    output logic [wts_pkg::COORD_W-1:0]          o_chosen_x,
    output logic [wts_pkg::COORD_W-1:0]          o_chosen_y,
    output logic [wts_pkg::COORD_W-1:0]          o_chosen_w,
    output logic [wts_pkg::COORD_W-1:0]          o_chosen_h,
    output logic [wts_pkg::CLS_W-1:0]            o_chosen_class
);

    localparam int CW = wts_pkg::COORD_W;

    // Configuration registers.
    logic                           r_enemy;
    logic [wts_pkg::WT_W-1:0]       r_wt_base, r_wt_std, r_wt_hero, r_wt_sentry, r_wt_size;
    logic signed [wts_pkg::WT_W-1:0] r_wt_dist;

    wts_pkg::t_state r_state, n_state;

    logic [wts_pkg::CNT_W-1:0]   r_count, r_j, r_k;
    logic [CW-1:0]               r_last_x, r_last_y;

    wts_pkg::t_box               mem_box [wts_pkg::MAX_BOXES];
    logic signed [wts_pkg::SCORE_W-1:0] mem_score [wts_pkg::MAX_BOXES];
    wts_pkg::t_box               r_rd_box, r_outer, r_chosen;
    logic signed [wts_pkg::SCORE_W-1:0] r_rd_score, r_cbest;
    logic [wts_pkg::SCORE_W-1:0] r_best, vsc;
    logic [wts_pkg::WT_W-1:0]    r_wt;
    logic [wts_pkg::CNT_W-1:0]   r_chosen_k;
    logic                        r_any, r_hit;

    logic                        accept, box_we, sc_start, sc_done;
    logic [wts_pkg::IDX_W-1:0]   rd_addr;
    logic signed [wts_pkg::SCORE_W-1:0] sc_score;
    logic                        is_vehicle, holds, is_enemy;

    logic                        r_valid, r_found;
    logic [wts_pkg::CHOSEN_IDX_W-1:0] r_o_idx;
    wts_pkg::t_box               r_o_box;

    assign accept = i_start && (r_state == wts_pkg::ST_IDLE);
    assign box_we = accept && (r_count < wts_pkg::CNT_W'(wts_pkg::MAX_BOXES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enemy     <= 1'b0;
            r_wt_base   <= 16'd200;
            r_wt_std    <= 16'd400;
            r_wt_hero   <= 16'd1000;
            r_wt_sentry <= 16'd300;
            r_wt_size   <= 16'd32;
            r_wt_dist   <= -16'sd256;
        end else if (i_cfg_we) begin
            unique case (wts_pkg::t_cfg_idx'(i_cfg_idx))
                wts_pkg::CFG_ENEMY_COLOR:     r_enemy     <= i_cfg_data[0];
                wts_pkg::CFG_WEIGHT_BASE:     r_wt_base   <= i_cfg_data;
                wts_pkg::CFG_WEIGHT_STANDARD: r_wt_std    <= i_cfg_data;
                wts_pkg::CFG_WEIGHT_HERO:     r_wt_hero   <= i_cfg_data;
                wts_pkg::CFG_WEIGHT_SENTRY:   r_wt_sentry <= i_cfg_data;
                wts_pkg::CFG_WEIGHT_SIZE:     r_wt_size   <= i_cfg_data;
                wts_pkg::CFG_WEIGHT_DIST:     r_wt_dist   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    wts_score u_score (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (sc_start),
        .i_box         (r_rd_box),
        .i_last_x      (r_last_x),
        .i_last_y      (r_last_y),
        .i_weight_size (r_wt_size),
        .i_weight_dist (r_wt_dist),
        .o_done        (sc_done),
        .o_score       (sc_score)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wts_pkg::ST_IDLE:      if (accept && i_last_box) n_state = wts_pkg::ST_PRE_RD;
            wts_pkg::ST_PRE_RD:    n_state = (r_j == r_count) ? wts_pkg::ST_OUT_RD
                                                              : wts_pkg::ST_PRE_GO;
            wts_pkg::ST_PRE_GO:    n_state = wts_pkg::ST_PRE_WAIT;
            wts_pkg::ST_PRE_WAIT:  if (sc_done) n_state = wts_pkg::ST_PRE_RD;
            wts_pkg::ST_OUT_RD:    n_state = (r_k == r_count) ? wts_pkg::ST_EMIT
                                                              : wts_pkg::ST_OUT_LATCH;
            wts_pkg::ST_OUT_LATCH: n_state = is_vehicle ? wts_pkg::ST_IN_RD
                                                        : wts_pkg::ST_OUT_RD;
            wts_pkg::ST_IN_RD:     n_state = (r_j == r_count) ? wts_pkg::ST_VEH_DONE
                                                              : wts_pkg::ST_IN_CHK;
            wts_pkg::ST_IN_CHK:    n_state = wts_pkg::ST_IN_RD;
            wts_pkg::ST_VEH_DONE:  n_state = wts_pkg::ST_OUT_RD;
            wts_pkg::ST_EMIT:      n_state = wts_pkg::ST_IDLE;
            default:               n_state = wts_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        sc_start = 1'b0;
        rd_addr  = r_j[wts_pkg::IDX_W-1:0];
        unique case (r_state)
            wts_pkg::ST_PRE_GO: sc_start = 1'b1;
            wts_pkg::ST_OUT_RD: rd_addr  = r_k[wts_pkg::IDX_W-1:0];
            default: begin
            end
        endcase
    end

    assign is_vehicle = (r_rd_box.cls == wts_pkg::CLS_BASE)
                     || (r_rd_box.cls == wts_pkg::CLS_STANDARD)
                     || (r_rd_box.cls == wts_pkg::CLS_HERO)
                     || (r_rd_box.cls == wts_pkg::CLS_SENTRY);

    // Strict containment on doubled coordinates, rearranged to avoid negatives.
    assign holds = ({1'b0, r_outer.y, 1'b0} + (CW+2)'(r_outer.h) > (CW+2)'({r_rd_box.y, 1'b0}))
                && ({1'b0, r_rd_box.y, 1'b0} + (CW+2)'(r_outer.h) > (CW+2)'({r_outer.y, 1'b0}))
                && ({1'b0, r_outer.x, 1'b0} + (CW+2)'(r_outer.w) > (CW+2)'({r_rd_box.x, 1'b0}))
                && ({1'b0, r_rd_box.x, 1'b0} + (CW+2)'(r_outer.w) > (CW+2)'({r_outer.x, 1'b0}));
    assign is_enemy = (r_rd_box.cls == wts_pkg::CLS_W'(r_enemy));

    assign vsc = $unsigned(wts_pkg::SCORE_W'({r_wt, 8'd0})) + $unsigned(r_cbest);

    always_ff @(posedge i_clk) begin
        if (box_we) begin
            mem_box[r_count[wts_pkg::IDX_W-1:0]] <= '{x: i_box_x, y: i_box_y, w: i_box_w,
                                                      h: i_box_h, cls: i_box_class};
        end
        if (r_state == wts_pkg::ST_PRE_WAIT && sc_done) begin
            mem_score[r_j[wts_pkg::IDX_W-1:0]] <= sc_score;
        end
        r_rd_box   <= mem_box[rd_addr];
        r_rd_score <= mem_score[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wts_pkg::ST_IDLE;
            r_count  <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_valid  <= 1'b0;
            r_found  <= 1'b0;
            r_hit    <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                wts_pkg::ST_IDLE: begin
                    if (box_we) r_count <= r_count + 1'b1;
                    r_j <= '0;
                end
                wts_pkg::ST_PRE_RD: begin
                    r_k    <= '0;
                    r_best <= '0;
                    r_hit  <= 1'b0;
                end
                wts_pkg::ST_PRE_WAIT: if (sc_done) r_j <= r_j + 1'b1;
                wts_pkg::ST_OUT_LATCH: begin
                    r_outer <= r_rd_box;
                    r_j     <= '0;
                    r_any   <= 1'b0;
                    r_cbest <= '0;
                    priority case (r_rd_box.cls)
                        wts_pkg::CLS_BASE:     r_wt <= r_wt_base;
                        wts_pkg::CLS_STANDARD: r_wt <= r_wt_std;
                        wts_pkg::CLS_HERO:     r_wt <= r_wt_hero;
                        default:               r_wt <= r_wt_sentry;
                    endcase
                    if (!is_vehicle) r_k <= r_k + 1'b1;
                end
                wts_pkg::ST_IN_CHK: begin
                    if (is_enemy && holds) begin
                        r_any <= 1'b1;
                        if (r_rd_score > r_cbest) r_cbest <= r_rd_score;
                    end
                    r_j <= r_j + 1'b1;
                end
                wts_pkg::ST_VEH_DONE: begin
                    if (r_any && vsc > r_best) begin
                        r_best     <= vsc;
                        r_chosen   <= r_outer;
                        r_chosen_k <= r_k;
                        r_hit      <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                end
                wts_pkg::ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_found <= r_hit;
                    r_count <= '0;
                    if (r_hit) begin
                        r_o_idx  <= wts_pkg::CHOSEN_IDX_W'(r_chosen_k);
                        r_o_box  <= r_chosen;
                        r_last_x <= r_chosen.x;
                        r_last_y <= r_chosen.y;
                    end else begin
                        r_o_idx <= '0;
                        r_o_box <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy         = (r_state != wts_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_chosen_index = r_o_idx;
    assign o_chosen_x     = r_o_box.x;
    assign o_chosen_y     = r_o_box.y;
    assign o_chosen_w     = r_o_box.w;
    assign o_chosen_h     = r_o_box.h;
    assign o_chosen_class = r_o_box.cls;

    `WTS_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == wts_pkg::ST_EMIT, o_valid)
    `WTS_ASSERT_NOW(a_empty_result, i_clk, i_rst_n, o_valid && !o_found,
        o_chosen_index == '0 && o_chosen_x == '0 && o_chosen_class == '0)
    `WTS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= wts_pkg::CNT_W'(wts_pkg::MAX_BOXES))
    `WTS_ASSERT_NEXT(a_frame_end_busy, i_clk, i_rst_n, i_start && !o_busy && i_last_box, o_busy)

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the weighted target selector against a predictor kept in the bench.
// Frames of boxes are sent, the chosen target of every frame is predicted or,
// for most directed frames, given by hand, and compared field by field with the outputs.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT = 40000;
    localparam int N_RANDOM   = 1500;

    typedef struct {
        logic                             found;
        logic [wts_pkg::CHOSEN_IDX_W-1:0] idx;
        wts_pkg::t_box                    box;
    } t_pick;

    typedef struct {
        wts_pkg::t_box box;
        logic          last;
        bit            typed;
        t_pick         pick;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_start;
    logic                             o_busy;
    logic [wts_pkg::COORD_W-1:0]      i_box_x, i_box_y, i_box_w, i_box_h;
    logic [wts_pkg::CLS_W-1:0]        i_box_class;
    logic                             i_last_box;
    logic                             i_cfg_we;
    logic [wts_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [wts_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             o_valid, o_found;
    logic [wts_pkg::CHOSEN_IDX_W-1:0] o_chosen_index;
    logic [wts_pkg::COORD_W-1:0]      o_chosen_x, o_chosen_y, o_chosen_w, o_chosen_h;
    logic [wts_pkg::CLS_W-1:0]        o_chosen_class;

    weighted_target_selector u_dut (.*);

    // Bench copy of the selector state and its registers.
    wts_pkg::t_box               frame_boxes [wts_pkg::MAX_BOXES];
    int                          frame_count;
    logic [wts_pkg::COORD_W-1:0] target_x, target_y;
    bit                          enemy_cls;
    logic [15:0]                 wt_base, wt_standard, wt_hero, wt_sentry, wt_size;
    logic signed [15:0]          wt_dist;

    t_pick pending_picks [$];
    int    mismatches;
    int    picks_seen;
    int    frames_found;
    int    boxes_sent;
    int    idle_cycles;
    bit    allow_gaps;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Appends an expected result behind those still outstanding.
    function automatic void expect_pick(input t_pick p);
        pending_picks = {pending_picks, p};
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic bit centre_inside(input wts_pkg::t_box o, input wts_pkg::t_box c);
        longint ox, oy, cx, cy, w, h;
        ox = 2 * longint'(o.x);
        oy = 2 * longint'(o.y);
        cx = 2 * longint'(c.x);
        cy = 2 * longint'(c.y);
        w  = longint'(o.w);
        h  = longint'(o.h);
        return (oy + h > cy) && (oy - h < cy) && (ox - w < cx) && (ox + w > cx);
    endfunction

    function automatic longint armour_score(input wts_pkg::t_box c);
        longint dx, dy;
        dx = longint'(c.x) - longint'(target_x);
        dy = longint'(c.y) - longint'(target_y);
        return longint'(c.w) * longint'(c.h) * longint'(wt_size)
             + int_sqrt(dx * dx + dy * dy) * longint'(wt_dist);
    endfunction

    function automatic longint vehicle_score(input int k);
        longint wt;
        longint top;
        longint s;
        bit     any;
        case (frame_boxes[k].cls)
            wts_pkg::CLS_BASE:     wt = wt_base;
            wts_pkg::CLS_STANDARD: wt = wt_standard;
            wts_pkg::CLS_HERO:     wt = wt_hero;
            wts_pkg::CLS_SENTRY:   wt = wt_sentry;
            default:               return 0;
        endcase
        any = 0;
        top = 0;
        for (int j = 0; j < frame_count; j++) begin
            if (frame_boxes[j].cls == wts_pkg::CLS_W'(enemy_cls) &&
                centre_inside(frame_boxes[k], frame_boxes[j])) begin
                s = armour_score(frame_boxes[j]);
                any = 1;
                if (s > top) top = s;
            end
        end
        return any ? (wt <<< 8) + top : 0;
    endfunction

    // Stores one box; on the final box of a frame returns the chosen target.
    function automatic bit select_target(input wts_pkg::t_box b, input logic last,
                                         output t_pick p);
        longint top;
        longint s;
        int     best_k;
        if (frame_count < wts_pkg::MAX_BOXES) begin
            frame_boxes[frame_count] = b;
            frame_count++;
        end
        if (!last) return 0;
        top    = 0;
        best_k = -1;
        for (int k = 0; k < frame_count; k++) begin
            s = vehicle_score(k);
            if (s > top) begin
                top    = s;
                best_k = k;
            end
        end
        p = '{found: 1'b0, idx: '0, box: '0};
        if (best_k >= 0) begin
            p.found  = 1'b1;
            p.idx    = wts_pkg::CHOSEN_IDX_W'(best_k);
            p.box    = frame_boxes[best_k];
            target_x = p.box.x;
            target_y = p.box.y;
        end
        frame_count = 0;
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            picks_seen++;
            if (o_found) frames_found++;
            if (pending_picks.size() == 0) begin
                report_mismatch("unexpected result, found", o_found, 0);
            end else begin
                t_pick e;
                e = pending_picks.pop_front();
                if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                if (o_chosen_index !== e.idx) report_mismatch("index", o_chosen_index, e.idx);
                if (o_chosen_x !== e.box.x) report_mismatch("x", o_chosen_x, e.box.x);
                if (o_chosen_y !== e.box.y) report_mismatch("y", o_chosen_y, e.box.y);
                if (o_chosen_w !== e.box.w) report_mismatch("w", o_chosen_w, e.box.w);
                if (o_chosen_h !== e.box.h) report_mismatch("h", o_chosen_h, e.box.h);
                if (o_chosen_class !== e.box.cls)
                    report_mismatch("class", o_chosen_class, e.box.cls);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending_picks.size());
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Drives one box from a falling edge and holds it until it is taken.
    task automatic send_box(input wts_pkg::t_box b, input logic last, input bit typed,
                            input t_pick tp);
        t_pick p;
        i_start     = 1'b1;
        i_box_x     = b.x;
        i_box_y     = b.y;
        i_box_w     = b.w;
        i_box_h     = b.h;
        i_box_class = b.cls;
        i_last_box  = last;
        do @(posedge i_clk); while (o_busy);
        if (select_target(b, last, p)) expect_pick(typed ? tp : p);
        boxes_sent++;
        @(negedge i_clk);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input wts_pkg::t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            wts_pkg::CFG_ENEMY_COLOR:     enemy_cls   = data[0];
            wts_pkg::CFG_WEIGHT_BASE:     wt_base     = data;
            wts_pkg::CFG_WEIGHT_STANDARD: wt_standard = data;
            wts_pkg::CFG_WEIGHT_HERO:     wt_hero     = data;
            wts_pkg::CFG_WEIGHT_SENTRY:   wt_sentry   = data;
            wts_pkg::CFG_WEIGHT_SIZE:     wt_size     = data;
            wts_pkg::CFG_WEIGHT_DIST:     wt_dist     = data;
            default: ;
        endcase
    endtask

    // Writes only with the block quiet: all results in and the scan finished.
    task automatic wait_quiet();
        i_start = 1'b0;
        while (pending_picks.size() != 0) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_weight(input int phase);
        case (phase % 4)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(($urandom_range(0, 7) + 1) * 64);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic new_settings(input int phase);
        logic [15:0] d;
        wait_quiet();
        write_reg(wts_pkg::CFG_ENEMY_COLOR, 16'($urandom));
        write_reg(wts_pkg::CFG_WEIGHT_BASE, pick_weight(phase));
        write_reg(wts_pkg::CFG_WEIGHT_STANDARD, pick_weight(phase + 1));
        write_reg(wts_pkg::CFG_WEIGHT_HERO, pick_weight(phase + 2));
        write_reg(wts_pkg::CFG_WEIGHT_SENTRY, pick_weight(phase + 3));
        write_reg(wts_pkg::CFG_WEIGHT_SIZE, pick_weight(phase + 2));
        case (phase % 5)
            0: d = 16'h8000;
            1: d = 16'h7FFF;
            2: d = 16'h0000;
            3: d = 16'(-$urandom_range(1, 1024));
            default: d = 16'($urandom);
        endcase
        write_reg(wts_pkg::CFG_WEIGHT_DIST, d);
    endtask

    function automatic logic [wts_pkg::COORD_W-1:0] near(input int c, input int span);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return wts_pkg::COORD_W'(v);
    endfunction

    // Mostly vehicles with armour placed inside them, some noise and full-range boxes.
    function automatic wts_pkg::t_box random_box(input wts_pkg::t_box host, input bit have_host);
        wts_pkg::t_box b;
        int            r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            b.cls = wts_pkg::CLS_W'($urandom_range(3, 6));
            b.x   = wts_pkg::COORD_W'($urandom);
            b.y   = wts_pkg::COORD_W'($urandom);
            b.w   = wts_pkg::COORD_W'($urandom_range(4, 600));
            b.h   = wts_pkg::COORD_W'($urandom_range(4, 600));
        end else if (r < 80 && have_host) begin
            b.cls = $urandom_range(0, 4) == 0 ? wts_pkg::CLS_W'(!enemy_cls)
                                              : wts_pkg::CLS_W'(enemy_cls);
            b.x   = near(host.x, host.w / 2 + 1);
            b.y   = near(host.y, host.h / 2 + 1);
            b.w   = wts_pkg::COORD_W'($urandom_range(0, 200));
            b.h   = wts_pkg::COORD_W'($urandom_range(0, 200));
        end else begin
            b.cls = wts_pkg::CLS_W'($urandom);
            b.x   = wts_pkg::COORD_W'($urandom);
            b.y   = wts_pkg::COORD_W'($urandom);
            b.w   = wts_pkg::COORD_W'($urandom);
            b.h   = wts_pkg::COORD_W'($urandom);
        end
        return b;
    endfunction

    t_row rows [$];

    function automatic t_row mk(input int x, y, w, h, c, input logic last,
                                input bit typed = 0);
        t_row r;
        r.box   = '{x: wts_pkg::COORD_W'(x), y: wts_pkg::COORD_W'(y),
                    w: wts_pkg::COORD_W'(w), h: wts_pkg::COORD_W'(h),
                    cls: wts_pkg::CLS_W'(c)};
        r.last  = last;
        r.typed = typed;
        r.pick  = '{found: 1'b0, idx: '0, box: '0};
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        rows = {rows, r};
    endfunction

    initial begin
        t_row          r;
        wts_pkg::t_box host;
        wts_pkg::t_box b;
        t_pick         none;
        bit            have_host;
        int            n;
        int            phase;
        int            frames;

        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_box_x = '0;
        i_box_y = '0;
        i_box_w = '0;
        i_box_h = '0;
        i_box_class = '0;
        i_last_box = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = wts_pkg::CFG_ENEMY_COLOR;
        i_cfg_data = '0;
        frame_count = 0;
        target_x = '0;
        target_y = '0;
        enemy_cls = 1'b0;
        wt_base = 200;
        wt_standard = 400;
        wt_hero = 1000;
        wt_sentry = 300;
        wt_size = 32;
        wt_dist = -256;
        mismatches = 0;
        picks_seen = 0;
        frames_found = 0;
        boxes_sent = 0;
        idle_cycles = 0;
        allow_gaps = 1;
        none = '{found: 1'b0, idx: '0, box: '0};

        // Directed frames on the reset settings.
        add_row(mk(0, 0, 0, 0, 0, 1, 1));               // lone armour, nothing found
        add_row(mk(4095, 4095, 4095, 4095, 15, 1, 1));  // extremes, nothing found
        add_row(mk(100, 100, 50, 50, wts_pkg::CLS_BASE, 0));
        r = mk(100, 100, 0, 0, 0, 1, 1);
        r.pick = '{found: 1'b1, idx: 0, box: rows[2].box};
        add_row(r);
        // Two equal hero boxes: the earlier one wins the tie.
        add_row(mk(500, 500, 40, 40, wts_pkg::CLS_HERO, 0));
        add_row(mk(500, 500, 40, 40, wts_pkg::CLS_HERO, 0));
        r = mk(500, 500, 2, 2, 0, 1, 1);
        r.pick = '{found: 1'b1, idx: 0, box: rows[4].box};
        add_row(r);
        // Centre on the edge of the vehicle is not inside.
        add_row(mk(10, 10, 4, 4, wts_pkg::CLS_STANDARD, 0));
        add_row(mk(12, 10, 1, 1, 0, 1, 1));
        // Armour of the friendly colour does not count.
        add_row(mk(2000, 2000, 100, 100, wts_pkg::CLS_SENTRY, 0));
        add_row(mk(2000, 2000, 5, 5, 1, 1, 1));
        // Non-vehicle class holding armour scores nothing.
        add_row(mk(800, 800, 90, 90, 7, 0));
        add_row(mk(800, 800, 9, 9, 0, 1, 1));
        add_row(mk(4095, 4095, 4095, 4095, wts_pkg::CLS_SENTRY, 0));
        add_row(mk(0, 0, 4095, 4095, wts_pkg::CLS_BASE, 0));
        add_row(mk(3000, 3000, 4095, 4095, 0, 0));
        add_row(mk(1, 1, 4095, 4095, 0, 0));
        add_row(mk(2500, 700, 300, 20, wts_pkg::CLS_STANDARD, 0));
        add_row(mk(2500, 700, 30, 3, 0, 1));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) send_box(rows[i].box, rows[i].last, rows[i].typed, rows[i].pick);

        phase = 0;
        frames = 0;
        have_host = 0;
        host = '0;
        while (boxes_sent < N_RANDOM + rows.size()) begin
            if (frames % 40 == 0) begin
                new_settings(phase);
                phase++;
            end
            allow_gaps = boxes_sent < N_RANDOM;
            // A few frames overfill the store so that late boxes are dropped.
            n = $urandom_range(0, 29) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 8);
            have_host = 0;
            for (int k = 0; k < n; k++) begin
                b = random_box(host, have_host);
                if (b.cls >= wts_pkg::CLS_BASE && b.cls <= wts_pkg::CLS_SENTRY) begin
                    host = b;
                    have_host = 1;
                end
                send_box(b, k == n - 1 ? 1'b1 : ($urandom_range(0, 63) == 0), 0, none);
            end
            frames++;
        end

        i_start = 1'b0;
        while (pending_picks.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);

        $display("%0d boxes sent over %0d setting phases; %0d frame results checked, %0d with a target",
                 boxes_sent, phase, picks_seen, frames_found);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
